// File: hdl/polyphonic_wavetable_oscillator_core_macros.svh
// Assertion macros for the polyphonic wavetable oscillator core.
// Used by the oscillator core in the hdl folder; expects signals clock and reset in scope.
`ifndef POLYPHONIC_WAVETABLE_OSCILLATOR_CORE_MACROS_SVH
`define POLYPHONIC_WAVETABLE_OSCILLATOR_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PWO_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PWO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pwo_pkg.sv
// Shared types and constants of the polyphonic wavetable oscillator.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package pwo_pkg;

   // Payload field widths
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int SAMPLE_W = 14;
   localparam int PHASE_W  = 15;
   localparam int MIX_W    = 16;

   typedef logic [OPCODE_W-1:0] opcode_type;

   // Request opcodes; the fourth code is unused and ignored
   localparam opcode_type OP_TICK       = 2'd0;
   localparam opcode_type OP_SET_INC    = 2'd1;
   localparam opcode_type OP_WRITE_WAVE = 2'd2;

   // Phase wraps modulo 2^15 - 1, increments clamp one below that
   localparam logic [PHASE_W:0]   PHASE_MOD = 16'h7FFF;
   localparam logic [VALUE_W-1:0] INC_MAX   = 16'd32766;

   // One voice memory word
   typedef struct packed {
      logic [PHASE_W-1:0] inc;
      logic [PHASE_W-1:0] phase;
   } voice_entry_type;

endpackage

// File: hdl/pwo_if.sv
// Request and response channel interfaces of the wavetable oscillator.
// Depends on pwo_pkg for the payload widths.
`timescale 1ns / 1ps

interface pwo_req_if;
   logic                          valid;
   logic                          ready;
   logic [pwo_pkg::OPCODE_W-1:0]  opcode;
   logic [pwo_pkg::INDEX_W-1:0]   index;
   logic [pwo_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output opcode, output index, output value, input ready);
   modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface pwo_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pwo_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/polyphonic_wavetable_oscillator_core.sv
// Polyphonic wavetable oscillator: a tick advances every voice phase and returns one
// mixed sample; other requests set a voice increment or write a wave table word.
// A tick walks the voice memory one voice per cycle through a four-stage
// read/update/lookup pipe and reads the wave table once per voice. Setting an
// increment reads the voice entry, then writes it back; writing a table word
// reduces the address, then writes the word. The finished sample sits in an
// output register, so new requests are taken while it waits; a tick that
// completes before it is taken holds in place. The wave table has no reset;
// voice state reads as zero until written.
`timescale 1ns / 1ps
`include "polyphonic_wavetable_oscillator_core_macros.svh"

module polyphonic_wavetable_oscillator_core #(
   parameter int VOICES      = 8,
   parameter int TABLE_DEPTH = 256,
   parameter int PHASE_SHIFT = 7
) (
   input  logic        clock,
   input  logic        reset,
   pwo_req_if.sink     req_chan,
   pwo_rsp_if.source   rsp_chan
);

   localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW        = $clog2(VOICES + 1);
   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int PW        = pwo_pkg::PHASE_W;
   localparam int RD_XW     = PW - PHASE_SHIFT;
   localparam int RD_RECIP  = (1 << RD_XW) / TABLE_DEPTH;
   localparam int WR_XW     = pwo_pkg::INDEX_W;
   localparam int WR_RECIP  = (1 << WR_XW) / TABLE_DEPTH;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TICK   = 3'd1;
   localparam logic [2:0] ST_OUT    = 3'd2;
   localparam logic [2:0] ST_INC_RD = 3'd3;
   localparam logic [2:0] ST_INC_WR = 3'd4;
   localparam logic [2:0] ST_WR_Q   = 3'd5;
   localparam logic [2:0] ST_WR_MEM = 3'd6;

   // Control registers
   logic [2:0]                    state_ff, state_in;
   logic [CW-1:0]                 iss_cnt_ff, iss_cnt_in;
   logic                          p1_v_ff, p1_v_in;
   logic                          p2_v_ff, p3_v_ff, p4_v_ff;
   logic [VOICES-1:0]             voice_valid_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [pwo_pkg::INDEX_W-1:0]   req_index_ff;
   logic [pwo_pkg::VALUE_W-1:0]   req_value_ff;
   logic [VW-1:0]                 p1_idx_ff;
   logic [RD_XW-1:0]              p2_x_ff, p3_x_ff, p3_q_ff;
   logic                          p2_act_ff, p3_act_ff, p4_act_ff;
   logic [WR_XW-1:0]              wr_q_ff;
   logic [pwo_pkg::MIX_W-1:0]     mix_ff, mix_in;
   logic [pwo_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;

   // Memories and their read registers
   pwo_pkg::voice_entry_type      voice_mem [VOICES];
   pwo_pkg::voice_entry_type      v_q_ff;
   logic                          vq_valid_ff;
   logic [pwo_pkg::VALUE_W-1:0]   tbl_mem [TABLE_DEPTH];
   logic [pwo_pkg::VALUE_W-1:0]   tbl_q_ff;

   // Memory port controls
   logic                          vm_we;
   logic [VW-1:0]                 vm_waddr, vm_raddr;
   pwo_pkg::voice_entry_type      vm_wdata;
   logic                          tbl_we;
   logic [AW-1:0]                 tbl_waddr, tbl_raddr;

   // Datapath nets
   logic                          req_xfer;
   pwo_pkg::voice_entry_type      cur;
   pwo_pkg::voice_entry_type      wb_entry;
   logic [PW:0]                   ph_sum;
   logic [PW-1:0]                 adv_phase;
   logic [PW-1:0]                 inc_clamped;
   logic [2*RD_XW-1:0]            rd_prod;
   logic [RD_XW:0]                rd_qt, rd_rem0, rd_rem;
   logic [31:0]                   rd_rem32;
   logic [2*WR_XW-1:0]            wr_prod;
   logic [WR_XW:0]                wr_qt, wr_rem0, wr_rem;
   logic [31:0]                   wr_rem32;

   assign req_xfer        = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = sample_ff;

   // Stage 1: phase update of the voice just read; unwritten voices read as zero
   assign cur       = vq_valid_ff ? v_q_ff : '0;
   assign ph_sum    = {1'b0, cur.phase} + {1'b0, cur.inc};
   assign adv_phase = (cur.inc == '0) ? '0 :
                      (ph_sum < pwo_pkg::PHASE_MOD) ? ph_sum[PW-1:0] :
                      PW'(ph_sum - pwo_pkg::PHASE_MOD);
   assign wb_entry  = '{inc: cur.inc, phase: adv_phase};

   // Stage 2/3: table address modulo depth by reciprocal and one correction
   assign rd_prod   = (2*RD_XW)'(p2_x_ff) * (2*RD_XW)'(RD_RECIP);
   assign rd_qt     = (RD_XW+1)'(32'(p3_q_ff) * 32'(TABLE_DEPTH));
   assign rd_rem0   = {1'b0, p3_x_ff} - rd_qt;
   assign rd_rem    = (32'(rd_rem0) >= 32'(TABLE_DEPTH)) ?
                      rd_rem0 - (RD_XW+1)'(TABLE_DEPTH) : rd_rem0;
   assign rd_rem32  = 32'(rd_rem);
   assign tbl_raddr = rd_rem32[AW-1:0];

   // Table write address, same reduction over the request index
   assign wr_prod   = (2*WR_XW)'(req_index_ff) * (2*WR_XW)'(WR_RECIP);
   assign wr_qt     = (WR_XW+1)'(32'(wr_q_ff) * 32'(TABLE_DEPTH));
   assign wr_rem0   = {1'b0, req_index_ff} - wr_qt;
   assign wr_rem    = (32'(wr_rem0) >= 32'(TABLE_DEPTH)) ?
                      wr_rem0 - (WR_XW+1)'(TABLE_DEPTH) : wr_rem0;
   assign wr_rem32  = 32'(wr_rem);
   assign tbl_waddr = wr_rem32[AW-1:0];

   assign inc_clamped = (req_value_ff > pwo_pkg::INC_MAX) ? pwo_pkg::INC_MAX[PW-1:0]
                                                          : req_value_ff[PW-1:0];

   // Sequencer and memory port control
   always_comb begin
      state_in     = state_ff;
      iss_cnt_in   = iss_cnt_ff;
      p1_v_in      = 1'b0;
      mix_in       = mix_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      vm_we        = p1_v_ff;
      vm_waddr     = p1_idx_ff;
      vm_wdata     = wb_entry;
      vm_raddr     = iss_cnt_ff[VW-1:0];
      tbl_we       = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate each active voice's table word as it returns
      if (p4_v_ff && p4_act_ff) begin
         mix_in = mix_ff + tbl_q_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_chan.opcode)
                  pwo_pkg::OP_TICK: begin
                     state_in   = ST_TICK;
                     iss_cnt_in = '0;
                     mix_in     = '0;
                  end
                  pwo_pkg::OP_SET_INC: begin
                     if (req_chan.index < pwo_pkg::INDEX_W'(VOICES)) begin
                        state_in = ST_INC_RD;
                     end
                  end
                  pwo_pkg::OP_WRITE_WAVE: begin
                     state_in = ST_WR_Q;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (iss_cnt_ff < CW'(VOICES)) begin
               p1_v_in    = 1'b1;
               iss_cnt_in = iss_cnt_ff + 1'b1;
            end else if (!p1_v_ff && !p2_v_ff && !p3_v_ff && !p4_v_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               sample_in    = mix_ff[pwo_pkg::MIX_W-1:2];
               state_in     = ST_IDLE;
            end
         end
         ST_INC_RD: begin
            vm_raddr = req_index_ff[VW-1:0];
            state_in = ST_INC_WR;
         end
         ST_INC_WR: begin
            // keep the running phase, replace the increment
            vm_we    = 1'b1;
            vm_waddr = req_index_ff[VW-1:0];
            vm_wdata = '{inc: inc_clamped, phase: cur.phase};
            state_in = ST_IDLE;
         end
         ST_WR_Q: begin
            state_in = ST_WR_MEM;
         end
         ST_WR_MEM: begin
            tbl_we   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         iss_cnt_ff     <= '0;
         p1_v_ff        <= 1'b0;
         p2_v_ff        <= 1'b0;
         p3_v_ff        <= 1'b0;
         p4_v_ff        <= 1'b0;
         voice_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_cnt_ff   <= iss_cnt_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p1_v_ff;
         p3_v_ff      <= p2_v_ff;
         p4_v_ff      <= p3_v_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (vm_we) begin
            voice_valid_ff[vm_waddr] <= 1'b1;
         end
      end
   end

   // Request capture and pipeline payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_index_ff <= req_chan.index;
         req_value_ff <= req_chan.value;
      end
      p1_idx_ff <= iss_cnt_ff[VW-1:0];
      p2_x_ff   <= RD_XW'(adv_phase >> PHASE_SHIFT);
      p2_act_ff <= (cur.inc != '0);
      p3_q_ff   <= rd_prod[2*RD_XW-1:RD_XW];
      p3_x_ff   <= p2_x_ff;
      p3_act_ff <= p2_act_ff;
      p4_act_ff <= p3_act_ff;
      wr_q_ff   <= wr_prod[2*WR_XW-1:WR_XW];
      mix_ff    <= mix_in;
      sample_ff <= sample_in;
   end

   // Voice memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (vm_we) begin
         voice_mem[vm_waddr] <= vm_wdata;
      end
      v_q_ff      <= voice_mem[vm_raddr];
      vq_valid_ff <= voice_valid_ff[vm_raddr];
   end

   // Wave table memory
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= req_value_ff;
      end
      tbl_q_ff <= tbl_mem[tbl_raddr];
   end

   // Checks
   `PWO_ASSERT(a_ready_idle_pipe, !req_chan.ready || (!p1_v_ff && !p2_v_ff && !p3_v_ff && !p4_v_ff), "request taken while voice pipe busy")
   `PWO_ASSERT(a_no_write_clash, !(p1_v_ff && (state_ff == ST_INC_WR)), "voice writeback and increment write collide")
   `PWO_ASSERT(a_issue_bound, iss_cnt_ff <= CW'(VOICES), "voice issue count past last voice")
   `PWO_ASSERT(a_rd_addr_range, !p3_v_ff || (32'(rd_rem) < 32'(TABLE_DEPTH)), "table read address not reduced")
   `PWO_ASSERT_NEXT(a_tick_start, req_xfer && (req_chan.opcode == pwo_pkg::OP_TICK), (state_ff == ST_TICK) && (iss_cnt_ff == '0), "tick transfer did not start voice walk")

endmodule
